// ===== hw/rtl/nla_pkg.sv =====
// shared constants and types for the nearest light assignment block
`default_nettype none
package nla_pkg;
   localparam int MaxLights   = 256;
   localparam int MaxAssigned = 8;
   localparam int IdxW        = (MaxLights > 1) ? $clog2(MaxLights) : 1;
   localparam int CntW        = $clog2(MaxLights + 1);
   localparam int SlotIdxW    = (MaxAssigned > 1) ? $clog2(MaxAssigned) : 1;
   localparam int SlotCntW    = $clog2(MaxAssigned + 1);
   localparam int LightW      = 3 * 24 + 23 + 3 * 16;
   localparam int DistW       = 50;

   localparam logic [1:0] OpClear  = 2'd0;
   localparam logic [1:0] OpAppend = 2'd1;
   localparam logic [1:0] OpQuery  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_WAIT = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_RD   = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear_count;
      logic append;
      logic load_query;
      logic scan_rd;
      logic sort_clear;
      logic emit_rd;
      logic emit_out;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_done;
      logic pipe_empty;
      logic emit_done;
   } status_type;
endpackage
`default_nettype wire

// ===== hw/rtl/nearest_light_assignment.sv =====
// top level of the nearest light assignment block
//
// usage: drive req_* with start while busy is low; the item transfers at that edge.
// operations: clear the table, append a light, query a model position.
// clear and append finish without leaving idle; busy stays low.
// a query reads all stored lights one per cycle through a four stage
// distance pipeline, keeping the nearest hits in a sorted slot list,
// then reads and returns the slots in turn, each marked by rsp_valid for one cycle.
// busy is high until the cycle that carries the last slot, where the next
// transfer can be taken. the scan rate is set by the single read port of the
// light table, which also serves the slot readout.
// empty slots return zero with present low; rsp_last marks the final slot.
// the receiver cannot stall: every result transfers in its cycle.
// reset empties the light table and returns the controller to idle.
`default_nettype none
module nearest_light_assignment (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [23:0] req_pos_z,
   input  wire logic [22:0]        req_radius,
   input  wire logic [15:0]        req_color_r,
   input  wire logic [15:0]        req_color_g,
   input  wire logic [15:0]        req_color_b,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_slot,
   output logic                    rsp_present,
   output logic signed [23:0]      rsp_light_x,
   output logic signed [23:0]      rsp_light_y,
   output logic signed [23:0]      rsp_light_z,
   output logic [22:0]             rsp_light_radius,
   output logic [15:0]             rsp_out_r,
   output logic [15:0]             rsp_out_g,
   output logic [15:0]             rsp_out_b,
   output logic                    rsp_last
);
   nla_pkg::cmd_type    cmd;
   nla_pkg::status_type status;

   nla_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_operation(req_operation),
      .status(status), .cmd(cmd), .busy(busy)
   );

   nla_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_radius(req_radius), .req_color_r(req_color_r),
      .req_color_g(req_color_g), .req_color_b(req_color_b),
      .rsp_valid(rsp_valid), .rsp_slot(rsp_slot), .rsp_present(rsp_present),
      .rsp_light_x(rsp_light_x), .rsp_light_y(rsp_light_y),
      .rsp_light_z(rsp_light_z), .rsp_light_radius(rsp_light_radius),
      .rsp_out_r(rsp_out_r), .rsp_out_g(rsp_out_g), .rsp_out_b(rsp_out_b),
      .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/nla_ram.sv =====
// generic ram with one write port and one registered read port
`default_nettype none
module nla_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/nla_ctrl.sv =====
// controller state machine for the light scan and slot output
`default_nettype none
module nla_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_operation,
   input  wire nla_pkg::status_type status,
   output nla_pkg::cmd_type         cmd,
   output logic                     busy
);
   nla_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nla_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != nla_pkg::ST_IDLE);
      case (state_ff)
         nla_pkg::ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  nla_pkg::OpClear: cmd.clear_count = 1'b1;
                  nla_pkg::OpAppend: cmd.append = !status.full;
                  nla_pkg::OpQuery: begin
                     cmd.load_query = 1'b1;
                     cmd.sort_clear = 1'b1;
                     state_in = nla_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         nla_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = nla_pkg::ST_WAIT;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         nla_pkg::ST_WAIT: begin
            if (status.pipe_empty) begin
               state_in = nla_pkg::ST_RD;
            end
         end
         nla_pkg::ST_RD: begin
            cmd.emit_rd = 1'b1;
            state_in = nla_pkg::ST_EMIT;
         end
         nla_pkg::ST_EMIT: begin
            cmd.emit_out = 1'b1;
            if (status.emit_done) begin
               state_in = nla_pkg::ST_IDLE;
            end else begin
               state_in = nla_pkg::ST_RD;
            end
         end
         default: state_in = nla_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/nla_dp.sv =====
// datapath: light table, distance pipeline, sorted slot list, output register
`default_nettype none
module nla_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire nla_pkg::cmd_type    cmd,
   output nla_pkg::status_type      status,
   input  wire logic signed [23:0]  req_pos_x,
   input  wire logic signed [23:0]  req_pos_y,
   input  wire logic signed [23:0]  req_pos_z,
   input  wire logic [22:0]         req_radius,
   input  wire logic [15:0]         req_color_r,
   input  wire logic [15:0]         req_color_g,
   input  wire logic [15:0]         req_color_b,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_slot,
   output logic                     rsp_present,
   output logic signed [23:0]       rsp_light_x,
   output logic signed [23:0]       rsp_light_y,
   output logic signed [23:0]       rsp_light_z,
   output logic [22:0]              rsp_light_radius,
   output logic [15:0]              rsp_out_r,
   output logic [15:0]              rsp_out_g,
   output logic [15:0]              rsp_out_b,
   output logic                     rsp_last
);
   localparam int IW = nla_pkg::IdxW;
   localparam int CW = nla_pkg::CntW;
   localparam int SW = nla_pkg::SlotIdxW;
   localparam int NW = nla_pkg::SlotCntW;
   localparam int MA = nla_pkg::MaxAssigned;
   localparam int DW = nla_pkg::DistW;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] scan_ff;
   logic signed [23:0] qx_ff, qy_ff, qz_ff;

   logic          ram_we;
   logic [IW-1:0] ram_wa, ram_ra;
   logic [nla_pkg::LightW-1:0] ram_wd, ram_rd;

   assign ram_we = cmd.append;
   assign ram_wa = count_ff[IW-1:0];
   assign ram_wd = {req_pos_x, req_pos_y, req_pos_z, req_radius,
                    req_color_r, req_color_g, req_color_b};

   logic [NW-1:0] used_ff;
   logic [IW-1:0] bidx_ff [MA];
   logic [DW-1:0] bd_ff [MA];
   logic [NW-1:0] emit_ff;

   assign ram_ra = cmd.emit_rd ? bidx_ff[emit_ff[SW-1:0]] : scan_ff[IW-1:0];

   nla_ram #(.Width(nla_pkg::LightW), .Depth(nla_pkg::MaxLights)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear_count) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         qx_ff <= req_pos_x;
         qy_ff <= req_pos_y;
         qz_ff <= req_pos_z;
         scan_ff <= '0;
      end else if (cmd.scan_rd) begin
         scan_ff <= scan_ff + CW'(1);
      end
   end

   // pipeline: s1 ram read, s2 differences, s3 squares, s4 sum and compare
   logic [3:0] v_ff;
   logic [IW-1:0] i1_ff, i2_ff, i3_ff, i4_ff;
   logic [24:0] dx2_ff, dy2_ff, dz2_ff;
   logic [22:0] r2_ff;
   logic [49:0] sx3_ff, sy3_ff, sz3_ff;
   logic [45:0] rr3_ff;
   logic [DW-1:0] d4_ff;
   logic          hit4_ff;

   logic signed [24:0] dxs, dys, dzs;
   logic [DW+1:0] dsum;
   always_comb begin
      dxs = 25'($signed(ram_rd[142:119])) - 25'(qx_ff);
      dys = 25'($signed(ram_rd[118:95])) - 25'(qy_ff);
      dzs = 25'($signed(ram_rd[94:71])) - 25'(qz_ff);
      dsum = (DW+2)'(sx3_ff) + (DW+2)'(sy3_ff) + (DW+2)'(sz3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], cmd.scan_rd};
      end
      i1_ff <= scan_ff[IW-1:0];
      i2_ff <= i1_ff;
      dx2_ff <= dxs[24] ? 25'(-dxs) : 25'(dxs);
      dy2_ff <= dys[24] ? 25'(-dys) : 25'(dys);
      dz2_ff <= dzs[24] ? 25'(-dzs) : 25'(dzs);
      r2_ff <= ram_rd[70:48];
      i3_ff <= i2_ff;
      sx3_ff <= dx2_ff * dx2_ff;
      sy3_ff <= dy2_ff * dy2_ff;
      sz3_ff <= dz2_ff * dz2_ff;
      rr3_ff <= r2_ff * r2_ff;
      i4_ff <= i3_ff;
      d4_ff <= DW'(dsum);
      hit4_ff <= (dsum < (DW+2)'(rr3_ff));
   end

   // sorted insertion list
   logic [MA-1:0] gt;
   always_comb begin
      for (int s = 0; s < MA; s++) begin
         gt[s] = (NW'(s) < used_ff) && (bd_ff[s] > d4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_clear) begin
         used_ff <= '0;
      end else if (v_ff[3] && hit4_ff && (gt[MA-1] || used_ff != NW'(MA))) begin
         for (int s = 0; s < MA; s++) begin
            if (gt[s]) begin
               if (s == 0 || gt[(s == 0) ? 0 : s - 1]) begin
                  if (s > 0) begin
                     bd_ff[s] <= bd_ff[(s == 0) ? 0 : s - 1];
                     bidx_ff[s] <= bidx_ff[(s == 0) ? 0 : s - 1];
                  end else begin
                     bd_ff[s] <= d4_ff;
                     bidx_ff[s] <= i4_ff;
                  end
               end else begin
                  bd_ff[s] <= d4_ff;
                  bidx_ff[s] <= i4_ff;
               end
            end else if (NW'(s) == used_ff) begin
               if (s > 0 && gt[(s == 0) ? 0 : s - 1]) begin
                  bd_ff[s] <= bd_ff[(s == 0) ? 0 : s - 1];
                  bidx_ff[s] <= bidx_ff[(s == 0) ? 0 : s - 1];
               end else begin
                  bd_ff[s] <= d4_ff;
                  bidx_ff[s] <= i4_ff;
               end
            end
         end
         if (used_ff != NW'(MA)) begin
            used_ff <= used_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_clear) begin
         emit_ff <= '0;
      end else if (cmd.emit_out) begin
         emit_ff <= emit_ff + NW'(1);
      end
   end

   logic pres;
   assign pres = emit_ff < used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit_out;
      end
      rsp_slot <= emit_ff[2:0];
      rsp_present <= pres;
      rsp_light_x <= pres ? ram_rd[142:119] : '0;
      rsp_light_y <= pres ? ram_rd[118:95] : '0;
      rsp_light_z <= pres ? ram_rd[94:71] : '0;
      rsp_light_radius <= pres ? ram_rd[70:48] : '0;
      rsp_out_r <= pres ? ram_rd[47:32] : '0;
      rsp_out_g <= pres ? ram_rd[31:16] : '0;
      rsp_out_b <= pres ? ram_rd[15:0] : '0;
      rsp_last <= (emit_ff == NW'(MA - 1));
   end

   assign status.full = (count_ff == CW'(nla_pkg::MaxLights));
   assign status.scan_done = (scan_ff == count_ff);
   assign status.pipe_empty = (v_ff == '0);
   assign status.emit_done = (emit_ff == NW'(MA - 1));
endmodule
`default_nettype wire

// ===== hw/rtl/nla_checker.sv =====
// port checker for the nearest light assignment block
`default_nettype none
module nla_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_present,
   input wire logic [2:0] rsp_slot,
   input wire logic [22:0] rsp_light_radius,
   input wire logic rsp_last
);
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy) else $error("result outside a query");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results in adjacent cycles");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy) else $error("busy after last slot");
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> rsp_light_radius == '0)
      else $error("empty slot not zero");
   a_first_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot == 3'd0 |-> !rsp_last) else $error("query too short");
endmodule

bind nearest_light_assignment nla_checker u_nla_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_present(rsp_present), .rsp_slot(rsp_slot),
   .rsp_light_radius(rsp_light_radius), .rsp_last(rsp_last)
);
`default_nettype wire
